// File: design/opb_pkg.sv
`timescale 1ns / 1ps

package opb_pkg;

    // default coordinate width, signed fixed point
    localparam int COORD_W_DEF = 32;

    // box length registers
    localparam int BOX_W = 31;
    localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;

    // periodic mask register
    localparam int MASK_W = 3;
    localparam logic [MASK_W-1:0] MASK_RESET = 3'd7;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd3;

    // opcodes
    localparam logic OP_WRAP  = 1'b0;
    localparam logic OP_IMAGE = 1'b1;

endpackage

// File: design/orthogonal_periodic_boundary.sv
`timescale 1ns / 1ps
// Periodic boundary unit for an orthorhombic box, signed fixed point.
// Input channel (s_axis): tuser carries the opcode (0 wrap A into the box,
// 1 minimum image of B minus A); tdata carries a_x, a_y, a_z, b_x, b_y, b_z.
// Output channel (m_axis): tdata carries res_x, res_y, res_z, each
// COORD_WIDTH+1 bits signed. One result per item, in order.
// Configuration: write i_cfg_we with i_cfg_addr 0..2 for the box lengths
// and 3 for the periodic mask; only while the unit is idle.
// Pipeline: one capture stage, one restoring remainder stage per magnitude
// bit, one fix-up/output stage. Throughput: one item per cycle while the
// receiver does not stall, set by the fully pipelined remainder chain, one
// bit per stage for all three axes.
// Reset (synchronous, active low) clears all valid bits and loads box
// lengths of 1.0 and all axes periodic.
// When the receiver stalls, the whole pipeline holds and o_s_axis_tready
// drops only while the output register is full and not taken; nothing is
// lost or repeated.
module orthogonal_periodic_boundary #(
    parameter int COORD_WIDTH = opb_pkg::COORD_W_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [opb_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [opb_pkg::BOX_W-1:0]            i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up, zero padded
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    // opcode
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // res_x, res_y, res_z from bit 0 up, zero padded
    output logic [((3*(COORD_WIDTH+1)+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int BW  = opb_pkg::BOX_W;
    localparam int XW  = ((DW > BW) ? DW : BW) + 2;
    localparam int NS  = DW;
    localparam int OTW = ((3*DW+7)/8)*8;

    // configuration registers
    logic [BW-1:0]             r_len [0:2];
    logic [opb_pkg::MASK_W-1:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[0] <= opb_pkg::BOX_RESET;
            r_len[1] <= opb_pkg::BOX_RESET;
            r_len[2] <= opb_pkg::BOX_RESET;
            r_mask   <= opb_pkg::MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                opb_pkg::CFG_BOX_X: r_len[0] <= i_cfg_data;
                opb_pkg::CFG_BOX_Y: r_len[1] <= i_cfg_data;
                opb_pkg::CFG_BOX_Z: r_len[2] <= i_cfg_data;
                opb_pkg::CFG_MASK:  r_mask   <= i_cfg_data[opb_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline storage: stage 0 captures, stages 1..NS take one bit each
    logic          r_vld [0:NS];
    logic          r_op  [0:NS];
    logic [DW-1:0] r_mag [0:NS][0:2];
    logic          r_neg [0:NS][0:2];
    logic [BW-1:0] r_rem [0:NS][0:2];
    logic          r_ovld;
    logic [3*DW-1:0] r_res;
    logic          en;

    // global advance: hold everything while the output is full and stalled
    assign en = !r_ovld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // capture stage: form A or B minus A and split into sign and magnitude
    logic [DW-1:0] n_val [0:2];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [DW-1:0] a_e;
            logic [DW-1:0] b_e;
            a_e = DW'($signed(i_s_axis_tdata[k*CW +: CW]));
            b_e = DW'($signed(i_s_axis_tdata[(k+3)*CW +: CW]));
            n_val[k] = (i_s_axis_tuser == opb_pkg::OP_IMAGE) ? (b_e - a_e) : a_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op[0] <= i_s_axis_tuser;
            for (int k = 0; k < 3; k++) begin
                r_neg[0][k] <= n_val[k][DW-1];
                r_mag[0][k] <= n_val[k][DW-1] ? (-n_val[k]) : n_val[k];
                r_rem[0][k] <= '0;
            end
        end
    end

    // restoring remainder stages, most significant magnitude bit first
    for (genvar s = 1; s <= NS; s++) begin : g_stage
        logic [BW-1:0] n_rem [0:2];
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                logic [BW:0] t;
                t = {r_rem[s-1][k], r_mag[s-1][k][DW-s]};
                if (t >= {1'b0, r_len[k]}) begin
                    n_rem[k] = BW'(t - {1'b0, r_len[k]});
                end else begin
                    n_rem[k] = t[BW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_op[s] <= r_op[s-1];
                for (int k = 0; k < 3; k++) begin
                    r_neg[s][k] <= r_neg[s-1][k];
                    r_mag[s][k] <= r_mag[s-1][k];
                    r_rem[s][k] <= n_rem[k];
                end
            end
        end
    end

    // fix-up: floor remainder for wrap, nearest image with halves away from zero
    logic [3*DW-1:0] n_res;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [XW-1:0] m;
            logic [XW-1:0] l;
            logic [XW-1:0] v;
            logic [XW-1:0] w;
            logic [XW-1:0] r;
            logic          per;
            m   = XW'(r_rem[NS][k]);
            l   = XW'(r_len[k]);
            v   = r_neg[NS][k] ? (-XW'(r_mag[NS][k])) : XW'(r_mag[NS][k]);
            per = r_mask[k] && (r_len[k] != '0);
            if (r_op[NS] == opb_pkg::OP_WRAP) begin
                w = (r_neg[NS][k] && (m != '0)) ? (l - m) : m;
            end else if ((m << 1) >= l) begin
                w = r_neg[NS][k] ? (l - m) : (m - l);
            end else begin
                w = r_neg[NS][k] ? (-m) : m;
            end
            r = per ? w : v;
            n_res[k*DW +: DW] = r[DW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = OTW'(r_res);

endmodule

// File: sim/opb_checker.sv
`timescale 1ns / 1ps

module opb_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [30:0]  i_cfg_data,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [191:0] i_s_data,
    input  logic         i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [103:0] i_m_data,
    output int           o_errors,
    output int           o_pending
);

    typedef struct packed {
        logic signed [32:0] z;
        logic signed [32:0] y;
        logic signed [32:0] x;
    } t_coord_res;

    logic [30:0] box_len [3];
    logic [2:0]  per_mask;
    t_coord_res  expected_q [$];
    int          n_err;
    int          n_out;

    assign o_errors  = n_err;
    assign o_pending = expected_q.size();

    // one axis: wrap into [0, L) or minimum image with halves away from zero
    function automatic logic signed [32:0] boundary_axis(logic op, logic signed [31:0] a,
                                                         logic signed [31:0] b,
                                                         logic [30:0] len, logic per);
        longint v;
        longint l;
        longint r;
        longint m;
        l = longint'(len);
        v = (op == opb_pkg::OP_WRAP) ? longint'(a) : longint'(b) - longint'(a);
        if (!per || l == 0)
            return v[32:0];
        r = v % l;
        if (op == opb_pkg::OP_WRAP) begin
            if (r < 0) r += l;
        end else begin
            m = (r < 0) ? -r : r;
            if (2 * m >= l) r = (r > 0) ? r - l : r + l;
        end
        return r[32:0];
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch item %0d %s: got %0d want %0d", n_out, what, got, want);
        n_err++;
    endtask

    // track registers, predict on accept, compare on result
    always @(posedge i_clk) begin
        t_coord_res e;
        t_coord_res g;
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) box_len[k] = opb_pkg::BOX_RESET;
            per_mask = opb_pkg::MASK_RESET;
            expected_q.delete();
            n_err = 0;
            n_out = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    opb_pkg::CFG_BOX_X: box_len[0] = i_cfg_data;
                    opb_pkg::CFG_BOX_Y: box_len[1] = i_cfg_data;
                    opb_pkg::CFG_BOX_Z: box_len[2] = i_cfg_data;
                    opb_pkg::CFG_MASK:  per_mask = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                e.x = boundary_axis(i_s_user, i_s_data[31:0], i_s_data[127:96],
                                    box_len[0], per_mask[0]);
                e.y = boundary_axis(i_s_user, i_s_data[63:32], i_s_data[159:128],
                                    box_len[1], per_mask[1]);
                e.z = boundary_axis(i_s_user, i_s_data[95:64], i_s_data[191:160],
                                    box_len[2], per_mask[2]);
                expected_q.push_back(e);
            end
            if (i_m_valid && i_m_ready) begin
                g = i_m_data[98:0];
                if (expected_q.size() == 0) begin
                    $display("unexpected result item %0d", n_out);
                    n_err++;
                end else begin
                    e = expected_q.pop_front();
                    if (g.x !== e.x) report("res_x", g.x, e.x);
                    if (g.y !== e.y) report("res_y", g.y, e.y);
                    if (g.z !== e.z) report("res_z", g.z, e.z);
                end
                n_out++;
            end
        end
    end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         cfg_we = 0;
    logic [1:0]   cfg_addr = '0;
    logic [30:0]  cfg_data = '0;
    logic         s_valid = 0;
    logic         s_ready;
    logic [191:0] s_data = '0;
    logic         s_user = 0;
    logic         m_valid;
    logic         m_ready = 0;
    logic [103:0] m_data;
    int           errors;
    int           pending;
    int           cycles = 0;
    bit           hold_off = 0;

    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 200000;

    orthogonal_periodic_boundary dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data)
    );

    opb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_user(s_user),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random wait per item, one long hold-off on request
    initial begin
        int w;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            w = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_ready <= 1;
            @(posedge i_clk);
            while (!m_valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    task automatic set_box(logic [30:0] lx, logic [30:0] ly, logic [30:0] lz,
                           logic [2:0] msk);
        write_reg(opb_pkg::CFG_BOX_X, lx);
        write_reg(opb_pkg::CFG_BOX_Y, ly);
        write_reg(opb_pkg::CFG_BOX_Z, lz);
        write_reg(opb_pkg::CFG_MASK, {28'd0, msk});
    endtask

    // offer one item, hold until accepted; gap drawn 0..4 unless burst
    task automatic send_pair(logic op, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                             bit burst);
        int g;
        g = burst ? 0 : $urandom_range(0, 4);
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_valid <= 1;
        s_user <= op;
        s_data <= {bz, by, bx, az, ay, ax};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    // coordinate near a multiple of the box, near the signed extremes, within one box of zero, or fully random
    function automatic logic [31:0] pick_coord(logic [30:0] len);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return $urandom_range(0, 3) * len + $urandom_range(0, 2) - 1;
            4: return -($urandom_range(0, 3) * len) + $urandom_range(0, 2) - 1;
            default: return $signed($urandom_range(0, 2 * len)) - $signed({1'b0, len});
        endcase
    endfunction

    task automatic drain();
        s_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, logic [30:0] lx, logic [30:0] ly, logic [30:0] lz);
        bit burst;
        for (int i = 0; i < n; i++) begin
            burst = (i / 40) % 3 == 0;
            send_pair(1'($urandom), pick_coord(lx), pick_coord(ly), pick_coord(lz),
                      pick_coord(lx), pick_coord(ly), pick_coord(lz), burst);
        end
        drain();
    endtask

    initial begin
        logic [30:0] lx;
        logic [30:0] ly;
        logic [30:0] lz;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed at reset values: extremes, halves, both opcodes
        send_pair(opb_pkg::OP_WRAP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 1'b0);
        send_pair(opb_pkg::OP_WRAP, -32'sd1, 32'h0001_0000, -32'sh1_0000, 32'hFFFF_FFFF,
                  0, 0, 1'b0);
        send_pair(opb_pkg::OP_IMAGE, 0, 0, 0, 32'h8000, -32'sh8000, 32'h1_8000, 1'b0);
        send_pair(opb_pkg::OP_IMAGE, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF, 1'b0);
        send_pair(opb_pkg::OP_IMAGE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 1'b0);
        drain();
        // zero lengths pass through, non-periodic difference in full
        set_box(31'd0, 31'h7FFF_FFFF, 31'd1, 3'b111);
        send_pair(opb_pkg::OP_IMAGE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_pair(opb_pkg::OP_WRAP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  0, 0, 0, 1'b0);
        send_pair(opb_pkg::OP_WRAP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -32'sd7, 0, 0, 0, 1'b0);
        drain();
        set_box(31'd3, 31'd4, 31'h4000_0000, 3'b000);
        send_pair(opb_pkg::OP_IMAGE, 32'h8000_0000, 5, 6, 32'h7FFF_FFFF, 7, 8, 1'b0);
        send_pair(opb_pkg::OP_WRAP, -32'sd5, 5, 32'h8000_0000, 0, 0, 0, 1'b0);
        drain();
        set_box(31'd3, 31'd4, 31'h4000_0000, 3'b111);
        send_pair(opb_pkg::OP_IMAGE, 0, 0, 0, 32'sd2, 32'sd2, 32'h6000_0000, 1'b0);
        send_pair(opb_pkg::OP_IMAGE, 0, 0, 0, -32'sd2, -32'sd6, -32'sh2000_0000, 1'b0);
        send_pair(opb_pkg::OP_WRAP, -32'sd1, -32'sd4, 32'h8000_0000, 0, 0, 0, 1'b0);
        drain();

        // random phases over several box settings
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin lx = 31'h1_0000; ly = 31'h7FFF_FFFF; lz = 31'd1; end
                1: begin lx = 31'h7FFF_FFFF; ly = 31'h4000_0000; lz = 31'h3FFF_FFFF; end
                2: begin lx = 31'd0; ly = 31'd2; lz = 31'h5_8000; end
                default: begin
                    lx = 31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 28));
                    ly = 31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 28));
                    lz = 31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 28));
                end
            endcase
            set_box(lx, ly, lz, (p < 3) ? 3'b111 : 3'($urandom_range(0, 7)));
            if (p == 4) hold_off = 1;
            random_phase(150, lx, ly, lz);
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
